[src/tlpm_pkg.sv]
// ----------------------------------------------------------------------------
// tlpm_pkg
// Shared types and constants for the two-level page map engine: request and
// response beats, directory entry layout, operation and status codes.
// ----------------------------------------------------------------------------
package tlpm_pkg;

    localparam int TABLE_SLOTS   = 16;
    localparam int TABLE_ENTRIES = 1024;

    localparam int IDX_W    = 10;
    localparam int VPN_W    = 20;
    localparam int FRAME_W  = 20;
    localparam int FLAGS_W  = 12;
    localparam int ENTRY_W  = FRAME_W + FLAGS_W;
    localparam int DIR_DEPTH = 1 << IDX_W;

    localparam int SLOT_W  = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
    localparam int CNT_W   = $clog2(TABLE_SLOTS + 1);
    localparam int TADDR_W = $clog2(TABLE_SLOTS * TABLE_ENTRIES);
    localparam int TBL_DEPTH = TABLE_SLOTS * TABLE_ENTRIES;

    localparam logic [1:0] KIND_MAP   = 2'd0;
    localparam logic [1:0] KIND_UNMAP = 2'd1;
    localparam logic [1:0] KIND_QUERY = 2'd2;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NO_SLOT = 2'd1;
    localparam logic [1:0] ST_ABSENT  = 2'd2;

    typedef struct packed {
        logic [1:0]         kind;
        logic [VPN_W-1:0]   virt_page;
        logic [FRAME_W-1:0] phys_frame;
        logic [FLAGS_W-1:0] page_flags;
    } cmd_t;

    typedef struct packed {
        logic [1:0] status;
        logic       is_mapped;
    } res_t;

    typedef struct packed {
        logic [SLOT_W-1:0] slot;
        logic              writable;
        logic              present;
    } dir_entry_t;

    localparam int DIR_W = $bits(dir_entry_t);

    // Flat table address of one entry within a slot.
    function automatic logic [TADDR_W-1:0] tbl_addr(
        input logic [SLOT_W-1:0] slot,
        input logic [IDX_W-1:0]  tidx
    );
        logic [SLOT_W+IDX_W-1:0] full;
        full = {slot, tidx};
        return full[TADDR_W-1:0];
    endfunction

endpackage

[src/two_level_page_map_engine_core.sv]
// ----------------------------------------------------------------------------
// two_level_page_map_engine_core
// Two-level page map: a directory memory of slot pointers and a table memory
// of page entries. Handles map (with table allocation), unmap and query; other kinds answer OK.
// ----------------------------------------------------------------------------
//
//  channel  dir  handshake              beat
//  -------  ---  ---------------------  ---------------------------------
//  cmd      in   cmd_valid / cmd_stall  kind, virt_page, phys_frame, flags
//  res      out  res_valid / res_stall  status, is_mapped
//
//  After reset every directory entry is cleared to not-present; cmd is
//  stalled until that pass ends.
//  Map into an existing table, unmap, missed query: directory read, then
//  table write (map, or unmap with a present table) and response. Hit query:
//  directory read, table read, response.
//  Map that allocates a table: directory read, a sweep that zeroes the new
//  slot one entry per cycle over the table write port, then the entry write
//  and response. A stalled response holds the engine at its last step; the
//  next cmd beat is still taken while a finished response waits.
//
module two_level_page_map_engine_core (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cmd_valid,
    output logic           cmd_stall,
    input  tlpm_pkg::cmd_t cmd,
    output logic           res_valid,
    input  logic           res_stall,
    output tlpm_pkg::res_t res
);
    import tlpm_pkg::*;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_DIR,
        S_CLEAR,
        S_ENTRY,
        S_TRD
    } state_t;

    state_t            state_reg, state_next;
    cmd_t              item_reg, item_next;
    logic [CNT_W-1:0]  free_reg, free_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic [IDX_W-1:0]  cnt_reg, cnt_next;
    res_t              res_reg, res_next;
    logic              res_valid_reg, res_valid_next;

    // Directory memory
    dir_entry_t        dir_mem [DIR_DEPTH];
    dir_entry_t        dir_rd_reg;
    logic              dir_we, dir_re;
    logic [IDX_W-1:0]  dir_waddr;
    dir_entry_t        dir_wdata;

    // Table memory
    logic [ENTRY_W-1:0] tbl_mem [TBL_DEPTH];
    logic [ENTRY_W-1:0] tbl_rd_reg;
    logic               tbl_we, tbl_re;
    logic [TADDR_W-1:0] tbl_waddr, tbl_raddr;
    logic [ENTRY_W-1:0] tbl_wdata;

    logic              can_load;
    logic [IDX_W-1:0]  tidx;
    logic [ENTRY_W-1:0] new_entry;

    assign cmd_stall = (state_reg != S_IDLE);
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    assign can_load  = !res_valid_reg || !res_stall;
    assign tidx      = item_reg.virt_page[IDX_W-1:0];
    assign new_entry = {item_reg.phys_frame, item_reg.page_flags};

    always_comb
    begin
        state_next     = state_reg;
        item_next      = item_reg;
        free_next      = free_reg;
        slot_next      = slot_reg;
        cnt_next       = cnt_reg;
        res_next       = res_reg;
        res_valid_next = res_valid_reg && res_stall;

        dir_we    = 1'b0;
        dir_re    = 1'b0;
        dir_waddr = item_reg.virt_page[VPN_W-1:IDX_W];
        dir_wdata = '0;
        tbl_we    = 1'b0;
        tbl_re    = 1'b0;
        tbl_waddr = tbl_addr(dir_rd_reg.slot, tidx);
        tbl_raddr = tbl_addr(dir_rd_reg.slot, tidx);
        tbl_wdata = '0;

        case (state_reg)
            S_INIT:
            begin
                // sweep the directory to not-present
                dir_we    = 1'b1;
                dir_waddr = cnt_reg;
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg == {IDX_W{1'b1}})
                begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    item_next  = cmd;
                    dir_re     = 1'b1;
                    state_next = S_DIR;
                end
            end

            S_DIR:
            begin
                case (item_reg.kind)
                    KIND_MAP:
                    begin
                        if (dir_rd_reg.present)
                        begin
                            if (can_load)
                            begin
                                tbl_we         = 1'b1;
                                tbl_wdata      = new_entry;
                                res_next       = '{status: ST_OK, is_mapped: 1'b0};
                                res_valid_next = 1'b1;
                                state_next     = S_IDLE;
                            end
                        end
                        else if (free_reg == CNT_W'(TABLE_SLOTS))
                        begin
                            if (can_load)
                            begin
                                res_next       = '{status: ST_NO_SLOT, is_mapped: 1'b0};
                                res_valid_next = 1'b1;
                                state_next     = S_IDLE;
                            end
                        end
                        else
                        begin
                            // allocate the next slot, then zero it
                            dir_we             = 1'b1;
                            dir_wdata.slot     = free_reg[SLOT_W-1:0];
                            dir_wdata.writable = 1'b1;
                            dir_wdata.present  = 1'b1;
                            slot_next          = free_reg[SLOT_W-1:0];
                            free_next          = CNT_W'(free_reg + 1'b1);
                            cnt_next           = '0;
                            state_next         = S_CLEAR;
                        end
                    end

                    KIND_UNMAP:
                    begin
                        if (can_load)
                        begin
                            if (dir_rd_reg.present)
                            begin
                                tbl_we   = 1'b1;
                                res_next = '{status: ST_OK, is_mapped: 1'b0};
                            end
                            else
                            begin
                                res_next = '{status: ST_ABSENT, is_mapped: 1'b0};
                            end
                            res_valid_next = 1'b1;
                            state_next     = S_IDLE;
                        end
                    end

                    KIND_QUERY:
                    begin
                        if (dir_rd_reg.present)
                        begin
                            tbl_re     = 1'b1;
                            state_next = S_TRD;
                        end
                        else if (can_load)
                        begin
                            res_next       = '{status: ST_OK, is_mapped: 1'b0};
                            res_valid_next = 1'b1;
                            state_next     = S_IDLE;
                        end
                    end

                    default:
                    begin
                        if (can_load)
                        begin
                            res_next       = '{status: ST_OK, is_mapped: 1'b0};
                            res_valid_next = 1'b1;
                            state_next     = S_IDLE;
                        end
                    end
                endcase
            end

            S_CLEAR:
            begin
                tbl_we    = 1'b1;
                tbl_waddr = tbl_addr(slot_reg, cnt_reg);
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg == {IDX_W{1'b1}})
                begin
                    state_next = S_ENTRY;
                end
            end

            S_ENTRY:
            begin
                if (can_load)
                begin
                    tbl_we         = 1'b1;
                    tbl_waddr      = tbl_addr(slot_reg, tidx);
                    tbl_wdata      = new_entry;
                    res_next       = '{status: ST_OK, is_mapped: 1'b0};
                    res_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            S_TRD:
            begin
                if (can_load)
                begin
                    res_next       = '{status: ST_OK, is_mapped: tbl_rd_reg[0]};
                    res_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            free_reg      <= '0;
            cnt_reg       <= '0;
            res_valid_reg <= 1'b0;
            res_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            free_reg      <= free_next;
            cnt_reg       <= cnt_next;
            res_valid_reg <= res_valid_next;
            res_reg       <= res_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        slot_reg <= slot_next;
    end

    always_ff @(posedge clk)
    begin
        if (dir_we)
        begin
            dir_mem[dir_waddr] <= dir_wdata;
        end
        if (dir_re)
        begin
            dir_rd_reg <= dir_mem[cmd.virt_page[VPN_W-1:IDX_W]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (tbl_we)
        begin
            tbl_mem[tbl_waddr] <= tbl_wdata;
        end
        if (tbl_re)
        begin
            tbl_rd_reg <= tbl_mem[tbl_raddr];
        end
    end

    // Pool pointer never runs past the pool.
    assert property (@(posedge clk) disable iff (!rst_n)
        free_reg <= CNT_W'(TABLE_SLOTS))
        else $error("free slot pointer beyond pool");

    // Pool pointer only ever steps up by one.
    assert property (@(posedge clk) disable iff (!rst_n)
        (free_reg != $past(free_reg)) |-> (free_reg == CNT_W'($past(free_reg) + 1'b1)))
        else $error("free slot pointer moved by other than one");

    // A slot being zeroed or filled has already been handed out.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR || state_reg == S_ENTRY) |-> (CNT_W'(slot_reg) < free_reg))
        else $error("working on a slot not yet allocated");

    // An accepted beat goes straight to the directory lookup.
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_valid && !cmd_stall) |=> (state_reg == S_DIR))
        else $error("accepted beat did not start a directory lookup");

endmodule

[dv/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the two-level page map engine. Drives map, unmap,
// query and no-op beats with random gaps and response back-pressure, predicts each
// response from a shadow directory and page table store, and compares every
// response field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb;
    import tlpm_pkg::*;

    localparam logic [1:0] KIND_NOP = 2'd3;
    localparam int CYCLE_LIMIT = 200000;
    localparam int RANDOM_BEATS = 880;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cmd_valid = 1'b0;
    logic cmd_stall;
    cmd_t cmd = '0;
    logic res_valid;
    logic res_stall = 1'b0;
    res_t res;

    // Shadow state of the page map
    logic                     dir_present [DIR_DEPTH];
    logic [SLOT_W-1:0]        dir_slot [DIR_DEPTH];
    logic [ENTRY_W-1:0]       page_entry [TBL_DEPTH];
    int                       slots_used = 0;

    res_t exp_results [$];
    int   fail_count = 0;
    int   res_seen = 0;
    int   stall_left = 0;
    int   cycle_count = 0;
    bit   tx_quiet = 1'b0;

    two_level_page_map_engine_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res)
    );

    initial
    begin
        forever
        begin
            #5 clk = ~clk;
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // Apply one beat to the shadow map and return the response it should give.
    function automatic res_t page_map_predict(input cmd_t c);
        res_t                    r;
        logic [IDX_W-1:0]        didx;
        logic [IDX_W-1:0]        tidx;
        logic [SLOT_W+IDX_W-1:0] at;
        r = '0;
        didx = c.virt_page[VPN_W-1:IDX_W];
        tidx = c.virt_page[IDX_W-1:0];
        case (c.kind)
            KIND_MAP:
            begin
                if (!dir_present[didx])
                begin
                    if (slots_used >= TABLE_SLOTS)
                    begin
                        r.status = ST_NO_SLOT;
                    end
                    else
                    begin
                        for (int e = 0; e < TABLE_ENTRIES; e++)
                        begin
                            page_entry[slots_used * TABLE_ENTRIES + e] = '0;
                        end
                        dir_slot[didx] = slots_used[SLOT_W-1:0];
                        dir_present[didx] = 1'b1;
                        slots_used++;
                    end
                end
                if (dir_present[didx])
                begin
                    at = {dir_slot[didx], tidx};
                    page_entry[at] = {c.phys_frame, c.page_flags};
                end
            end
            KIND_UNMAP:
            begin
                if (dir_present[didx])
                begin
                    at = {dir_slot[didx], tidx};
                    page_entry[at] = '0;
                end
                else
                begin
                    r.status = ST_ABSENT;
                end
            end
            KIND_QUERY:
            begin
                if (dir_present[didx])
                begin
                    at = {dir_slot[didx], tidx};
                    r.is_mapped = page_entry[at][0];
                end
            end
            default:
            begin
                r = '0;
            end
        endcase
        return r;
    endfunction

    // Send one command beat after a random gap; record its prediction on accept.
    task automatic send_cmd(
        input logic [1:0]         kind,
        input logic [VPN_W-1:0]   vpn,
        input logic [FRAME_W-1:0] frame,
        input logic [FLAGS_W-1:0] flags
    );
        cmd_t c;
        int   gap;
        c.kind = kind;
        c.virt_page = vpn;
        c.phys_frame = frame;
        c.page_flags = flags;
        gap = tx_quiet ? 0 : $urandom_range(0, 9);
        if (gap != 0)
        begin
            cmd_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_valid <= 1'b1;
        cmd <= c;
        do
        begin
            @(posedge clk);
        end
        while (cmd_stall);
        exp_results.push_back(page_map_predict(c));
    endtask

    // Response side: check each beat, then draw the stall for the next one.
    always @(posedge clk)
    begin
        res_t want;
        if (res_valid && !res_stall)
        begin
            if (exp_results.size() == 0)
            begin
                $error("unexpected response beat: status %0d is_mapped %0d",
                       res.status, res.is_mapped);
                fail_count++;
            end
            else
            begin
                want = exp_results.pop_front();
                if (res.status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, res.status);
                    fail_count++;
                end
                if (res.is_mapped !== want.is_mapped)
                begin
                    $error("is_mapped: expected %0d, got %0d",
                           want.is_mapped, res.is_mapped);
                    fail_count++;
                end
            end
            res_seen++;
            if (((res_seen / 80) % 3) == 1)
                stall_left = 0;
            else
                stall_left = $urandom_range(0, 9);
            res_stall <= (stall_left != 0);
        end
        else if (res_stall)
        begin
            stall_left--;
            res_stall <= (stall_left != 0);
        end
    end

    task automatic test_basic_ops();
        tx_quiet = 1'b0;
        // absent directory entry
        send_cmd(KIND_QUERY, 20'h00000, 20'h12345, 12'h001);
        send_cmd(KIND_UNMAP, 20'h00000, 20'h00000, 12'h000);
        send_cmd(KIND_NOP,   20'h00000, 20'h00000, 12'h000);
        // first map allocates a table
        send_cmd(KIND_MAP,   20'h00000, 20'h00000, 12'hFFF);
        send_cmd(KIND_QUERY, 20'h00000, 20'h00000, 12'h000);
        // present bit clear in the flags still writes the entry
        send_cmd(KIND_MAP,   20'h003FF, 20'hFFFFF, 12'h000);
        send_cmd(KIND_QUERY, 20'h003FF, 20'h00000, 12'h000);
        send_cmd(KIND_MAP,   20'hFFFFF, 20'hFFFFF, 12'hFFF);
        send_cmd(KIND_QUERY, 20'hFFFFF, 20'hFFFFF, 12'hFFF);
        // neighbor in a freshly cleared table
        send_cmd(KIND_QUERY, 20'hFFC00, 20'h00000, 12'h000);
        send_cmd(KIND_UNMAP, 20'hFFFFF, 20'hFFFFF, 12'hFFF);
        send_cmd(KIND_QUERY, 20'hFFFFF, 20'h00000, 12'h000);
        send_cmd(KIND_UNMAP, 20'h00001, 20'h00000, 12'h000);
        send_cmd(KIND_MAP,   20'h00001, 20'hAAAAA, 12'h555);
        send_cmd(KIND_QUERY, 20'h00001, 20'h00000, 12'h000);
        send_cmd(KIND_MAP,   20'h00002, 20'h55555, 12'hAAA);
        send_cmd(KIND_QUERY, 20'h00002, 20'h00000, 12'h000);
        send_cmd(KIND_NOP,   20'hFFFFF, 20'hFFFFF, 12'hFFF);
        send_cmd(KIND_QUERY, 20'h00000, 20'h00000, 12'h000);
    endtask

    task automatic test_random_traffic();
        int                 hot_dir [24];
        int                 hot_tidx [16];
        int                 pick;
        logic [1:0]         kind;
        logic [IDX_W-1:0]   didx;
        logic [IDX_W-1:0]   tidx;
        hot_dir[0] = 0;
        hot_dir[1] = DIR_DEPTH - 1;
        for (int i = 2; i < 24; i++)
            hot_dir[i] = $urandom_range(0, DIR_DEPTH - 1);
        hot_tidx[0] = 0;
        hot_tidx[1] = TABLE_ENTRIES - 1;
        for (int i = 2; i < 16; i++)
            hot_tidx[i] = $urandom_range(0, TABLE_ENTRIES - 1);
        for (int i = 0; i < RANDOM_BEATS; i++)
        begin
            tx_quiet = ((i / 100) % 4) == 3;
            pick = $urandom_range(0, 99);
            if (pick < 35)
                kind = KIND_MAP;
            else if (pick < 55)
                kind = KIND_UNMAP;
            else if (pick < 95)
                kind = KIND_QUERY;
            else
                kind = KIND_NOP;
            // keep most traffic on a few tables so maps and queries meet
            if ($urandom_range(0, 99) < 85)
                didx = IDX_W'(hot_dir[$urandom_range(0, 23)]);
            else
                didx = IDX_W'($urandom_range(0, DIR_DEPTH - 1));
            if ($urandom_range(0, 99) < 70)
                tidx = IDX_W'(hot_tidx[$urandom_range(0, 15)]);
            else
                tidx = IDX_W'($urandom_range(0, TABLE_ENTRIES - 1));
            send_cmd(kind, {didx, tidx},
                     FRAME_W'($urandom_range(0, (1 << FRAME_W) - 1)),
                     FLAGS_W'($urandom_range(0, (1 << FLAGS_W) - 1)));
        end
    endtask

    task automatic test_pool_exhaustion();
        logic [IDX_W-1:0] didx;
        logic [IDX_W-1:0] used_dir;
        tx_quiet = 1'b0;
        // fill the remaining slots
        while (slots_used < TABLE_SLOTS)
        begin
            do
                didx = IDX_W'($urandom_range(0, DIR_DEPTH - 1));
            while (dir_present[didx]);
            send_cmd(KIND_MAP, {didx, 10'($urandom_range(0, TABLE_ENTRIES - 1))},
                     FRAME_W'($urandom_range(0, (1 << FRAME_W) - 1)), 12'h001);
        end
        // pick any directory entry that owns a table
        used_dir = '0;
        for (int i = 0; i < DIR_DEPTH; i++)
        begin
            if (dir_present[i])
                used_dir = IDX_W'(i);
        end
        do
            didx = IDX_W'($urandom_range(0, DIR_DEPTH - 1));
        while (dir_present[didx]);
        send_cmd(KIND_MAP,   {didx, 10'h3FF}, 20'hFFFFF, 12'hFFF);
        send_cmd(KIND_MAP,   {didx, 10'h000}, 20'h00001, 12'h001);
        send_cmd(KIND_QUERY, {didx, 10'h3FF}, 20'h00000, 12'h000);
        send_cmd(KIND_UNMAP, {didx, 10'h3FF}, 20'h00000, 12'h000);
        // existing tables keep working with the pool empty
        send_cmd(KIND_MAP,   {used_dir, 10'h155}, 20'hABCDE, 12'h001);
        send_cmd(KIND_QUERY, {used_dir, 10'h155}, 20'h00000, 12'h000);
        send_cmd(KIND_UNMAP, {used_dir, 10'h155}, 20'h00000, 12'h000);
        send_cmd(KIND_QUERY, {used_dir, 10'h155}, 20'h00000, 12'h000);
    endtask

    initial
    begin
        for (int i = 0; i < DIR_DEPTH; i++)
        begin
            dir_present[i] = 1'b0;
            dir_slot[i] = '0;
        end
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_basic_ops();
        test_random_traffic();
        test_pool_exhaustion();

        cmd_valid <= 1'b0;
        while (exp_results.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
